// File: design/assert_macros.svh
// Assertion macros used by the cache top level. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lruc_pkg.sv
package lruc_pkg;

   localparam int CacheEntries = 16;
   localparam int SlotW        = $clog2(CacheEntries);
   localparam int CntW         = $clog2(CacheEntries + 1);
   localparam int KeyW         = 32;
   localparam int ValW         = 32;
   localparam int OpW          = 2;
   localparam int CsrDataW     = 32;
   localparam int CsrAddrW     = 3;
   localparam int CsrLimitW    = 5;
   localparam int LimW         = (CntW > CsrLimitW) ? CntW : CsrLimitW;

   localparam logic [CsrLimitW-1:0] LimitReset = CsrLimitW'(16);

   typedef enum logic [OpW-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2
   } opcode_type;

   // Register indexes on the configuration port.
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   typedef struct packed {
      logic [OpW-1:0]  opcode;
      logic [KeyW-1:0] key;
   } dir_req_type;

   typedef struct packed {
      logic             hit;
      logic [SlotW-1:0] hit_slot;
      logic             fill;
      logic [SlotW-1:0] fill_slot;
   } dir_rsp_type;

   typedef struct packed {
      logic [CntW-1:0]         count;
      logic [CacheEntries-1:0] valid;
      logic [CacheEntries-1:0] match;
   } dir_stat_type;

endpackage

// File: design/lru_key_value_cache.sv
// Fully associative key-to-value cache with least-recently-used replacement.
// Requests enter on the req_ channel (opcode, key, value) under valid/ready and
// each gives exactly one result on the rsp_ channel (found, value_out), in order.
// A lookup hit returns the stored value and makes the entry most recent; an insert
// of an absent key stores it, evicting the least recent entry when the limit is
// reached; an erase frees the entry. Both report whether the key was present.
// A request passes through the request register, then the result register, which is
// loaded together with the registered read of the value memory. Throughput is one
// request per cycle while the receiver takes each result, as the tag compare and
// rank update over all slots are combinational.
// The csr_ port holds entries_in_use at byte address 0; values of zero act as one
// and values above the capacity act as the capacity.
// Reset empties the cache and sets entries_in_use to 16.
// While the receiver stalls the result holds, one further request is taken into
// the request register, and req_ready then stays low until the result is taken.
`include "assert_macros.svh"

module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lruc_pkg::OpW-1:0]      req_opcode,
   input  logic [lruc_pkg::KeyW-1:0]     req_lookup_key,
   input  logic [lruc_pkg::ValW-1:0]     req_value_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [lruc_pkg::ValW-1:0]     rsp_value_out,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lruc_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [lruc_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [lruc_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);
   import lruc_pkg::*;

   logic                 in_valid_ff;
   logic [OpW-1:0]       in_opcode_ff;
   logic [KeyW-1:0]      in_key_ff;
   logic [ValW-1:0]      in_value_ff;
   logic                 rsp_valid_ff, rsp_found_ff, rsp_show_ff;
   logic [CsrLimitW-1:0] limit_ff;
   logic [LimW-1:0]      eff_limit;
   logic                 advance, csr_write;
   logic [ValW-1:0]      ram_rd_data;
   dir_req_type          dir_req;
   dir_rsp_type          dir_rsp;
   dir_stat_type         dir_stat;
   logic                 count_ok, erase_hit;
   logic [CntW-1:0]      count_dec;

   // A request moves on once the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_ENTRIES_IN_USE) begin
         csr_prdata = CsrDataW'(limit_ff);
      end
   end

   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = LimW'(1);
      end else if (LimW'(limit_ff) > LimW'(CacheEntries)) begin
         eff_limit = LimW'(CacheEntries);
      end else begin
         eff_limit = LimW'(limit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitReset;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_ENTRIES_IN_USE)) begin
            limit_ff <= csr_pwdata[CsrLimitW-1:0];
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_opcode_ff <= req_opcode;
         in_key_ff    <= req_lookup_key;
         in_value_ff  <= req_value_in;
      end
      if (advance) begin
         rsp_found_ff <= dir_rsp.hit;
         rsp_show_ff  <= dir_rsp.hit && (in_opcode_ff == OP_LOOKUP);
      end
   end

   assign dir_req.opcode = in_opcode_ff;
   assign dir_req.key    = in_key_ff;

   lruc_dir u_dir (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .req   (dir_req),
      .limit (eff_limit),
      .rsp   (dir_rsp),
      .stat  (dir_stat)
   );

   // The value store is read only when a result is loaded, so its output holds during a stall.
   lruc_ram #(
      .Width (ValW),
      .Depth (CacheEntries)
   ) u_values (
      .clock   (clock),
      .wr_en   (advance && dir_rsp.fill),
      .wr_addr (dir_rsp.fill_slot),
      .wr_data (in_value_ff),
      .rd_en   (advance),
      .rd_addr (dir_rsp.hit_slot),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_value_out = rsp_show_ff ? ram_rd_data : '0;

   assign count_ok  = (dir_stat.count == CntW'($countones(dir_stat.valid)));
   assign erase_hit = advance && dir_rsp.hit && (in_opcode_ff == OP_ERASE);
   assign count_dec = dir_stat.count - CntW'(1);

   `ASSERT_ALWAYS(a_count_tracks_valid, count_ok, "entry count out of step with valid bits")
   `ASSERT_ALWAYS(a_single_match, $onehot0(dir_stat.match), "key held in more than one slot")
   `ASSERT_NEXT(a_erase_frees, erase_hit, dir_stat.count == $past(count_dec), "erase kept entry")

endmodule

// File: design/lruc_ram.sv
module lruc_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lruc_dir.sv
module lruc_dir (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  lruc_pkg::dir_req_type     req,
   input  logic [lruc_pkg::LimW-1:0] limit,
   output lruc_pkg::dir_rsp_type     rsp,
   output lruc_pkg::dir_stat_type    stat
);
   import lruc_pkg::*;

   logic [KeyW-1:0]         key_ff   [CacheEntries];
   logic [CacheEntries-1:0] valid_ff, valid_in;
   logic [SlotW-1:0]        rank_ff  [CacheEntries];
   logic [SlotW-1:0]        rank_in  [CacheEntries];
   logic [CntW-1:0]         count_ff, count_in;

   logic [CacheEntries-1:0] match, evict, keep;
   logic                    op_ok, is_lookup, is_insert, is_erase;
   logic                    hit_any, full, touch, fill, drop;
   logic [SlotW-1:0]        hit_slot, hit_rank, fill_slot;

   always_comb begin
      is_lookup = (req.opcode == OP_LOOKUP);
      is_insert = (req.opcode == OP_INSERT);
      is_erase  = (req.opcode == OP_ERASE);
      op_ok     = is_lookup || is_insert || is_erase;

      hit_slot = '0;
      hit_rank = '0;
      for (int i = 0; i < CacheEntries; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req.key);
         if (match[i]) begin
            hit_slot = hit_slot | SlotW'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      hit_any = |match;

      // When the cache is at its limit, every entry from rank limit-1 upwards goes at once.
      full = (LimW'(count_ff) >= limit);
      for (int i = 0; i < CacheEntries; i++) begin
         evict[i] = full && valid_ff[i] && (LimW'(rank_ff[i]) >= (limit - LimW'(1)));
         keep[i]  = valid_ff[i] && !evict[i];
      end

      fill_slot = '0;
      for (int i = CacheEntries - 1; i >= 0; i--) begin
         if (!keep[i]) begin
            fill_slot = SlotW'(i);
         end
      end

      touch = (is_lookup || is_insert) && hit_any;
      fill  = is_insert && !hit_any;
      drop  = is_erase && hit_any;

      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      for (int i = 0; i < CacheEntries; i++) begin
         if (touch) begin
            if (match[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + SlotW'(1);
            end
         end else if (drop) begin
            if (match[i]) begin
               valid_in[i] = 1'b0;
               rank_in[i]  = '0;
            end else if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
               rank_in[i] = rank_ff[i] - SlotW'(1);
            end
         end else if (fill) begin
            if (SlotW'(i) == fill_slot) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else begin
               valid_in[i] = keep[i];
               if (keep[i]) begin
                  rank_in[i] = rank_ff[i] + SlotW'(1);
               end
            end
         end
      end

      if (fill) begin
         count_in = full ? CntW'(limit) : (count_ff + CntW'(1));
      end else if (drop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CacheEntries; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (go) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && fill) begin
         key_ff[fill_slot] <= req.key;
      end
   end

   assign rsp.hit       = hit_any && op_ok;
   assign rsp.hit_slot  = hit_slot;
   assign rsp.fill      = fill;
   assign rsp.fill_slot = fill_slot;

   assign stat.count = count_ff;
   assign stat.valid = valid_ff;
   assign stat.match = match;

endmodule
